// ----- sv/polyline_3d_interpolator_macros.svh -----
// Assertion macros used by the top-level RTL file of the polyline interpolator.
`ifndef POLYLINE_3D_INTERPOLATOR_MACROS_SVH
`define POLYLINE_3D_INTERPOLATOR_MACROS_SVH

// Generic clocked assertion with an active-low reset that disables it.
`define PLINT_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion on the house clock and reset.
`define PLINT_ASSERT(lbl, prop, msg) \
  `PLINT_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- sv/plint_pkg.sv -----
// Types and constants of the polyline interpolator.
`default_nettype none

package plint_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned CountW   = 7;
  localparam int unsigned LenW     = 31;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [3:0] {
    ACT_ADVANCE     = 4'd0,
    ACT_EVALUATE    = 4'd1,
    ACT_SET_A       = 4'd2,
    ACT_SET_B       = 4'd3,
    ACT_STACK       = 4'd4,
    ACT_MOVETO      = 4'd5,
    ACT_LOAD_POINT  = 4'd6,
    ACT_SET_SEGMENT = 4'd7,
    ACT_SET_PHASE   = 4'd8
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OFFSET_X     = 3'd0,
    CFG_OFFSET_Y     = 3'd1,
    CFG_OFFSET_Z     = 3'd2,
    CFG_STRIDE       = 3'd3,
    CFG_SEG_LENGTH   = 3'd4,
    CFG_AUTO_ADVANCE = 3'd5
  } cfg_index_e;

  localparam logic signed [CoordW-1:0] STRIDE_RESET = 32'sd655;    // 0.01
  localparam logic [LenW-1:0]          LENGTH_RESET = 31'd65536;   // 1.0
  localparam logic signed [CoordW-1:0] ONE_Q16      = 32'sd65536;
  localparam logic [CountW-1:0]        COUNT_TWO    = 7'd2;
  localparam logic [CountW-1:0]        COUNT_ONE    = 7'd1;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } point_t;

  typedef struct packed {
    logic [3:0]               action;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_z;
    logic signed [CoordW-1:0] position;
    logic [IdxW-1:0]          point_index;
    logic                     last_point;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_z;
    logic                     segment_end;
    logic                     path_end;
  } out_item_t;

endpackage

`default_nettype wire

// ----- sv/plint_stream_if.sv -----
// Valid/ready stream interface carrying one payload beat.
`default_nettype none

interface plint_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/polyline_3d_interpolator.sv -----
// Top level of the polyline interpolator: control state, pipeline and output.
//
//  channel  dir  handshake          payload
//  in_i     in   valid/ready        action, coord_x/y/z, position, point_index, last_point
//  out_o    out  valid/ready        out_x/y/z, segment_end, path_end
//  cfg      in   cfg_we_i only      cfg_index_i, cfg_data_i
//
// One item is accepted per cycle unless stage 1 stalls.
// Phase, segment and count update in the accept cycle; the point store read
// lands in the cycle after the accept and feeds the endpoint registers in stage 1.
// Stages: store read, difference, multiply, add/saturate into the output register.
// Each stage stalls only when it is full and the stage after it is stalled.
// Reset sets control state to its reset values; the point store holds no reset value.
`default_nettype none

module polyline_3d_interpolator #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [plint_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [plint_pkg::CfgDataW-1:0]     cfg_data_i,
  plint_stream_if.sink                            in_i,
  plint_stream_if.source                          out_o
);

  `include "polyline_3d_interpolator_macros.svh"

  localparam int AW = $clog2(MAX_POINTS);
  localparam logic signed [50:0] SAT_HI = 51'sd2147483647;
  localparam logic signed [50:0] SAT_LO = -51'sd2147483648;

  typedef struct packed {
    logic              emit;
    logic              use_mem;
    logic              set_a;
    logic              set_b;
    logic              stack;
    logic              moveto;
    plint_pkg::point_t coord;
    logic signed [31:0] pos;
    logic              seg_end;
    logic              path_end;
  } s1_op_t;

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7fffffff;
    end else if (v < SAT_LO) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- config
  logic signed [31:0] off_x_q, off_y_q, off_z_q, stride_q;
  logic [plint_pkg::LenW-1:0] len_q;
  logic auto_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q  <= '0;
      off_y_q  <= '0;
      off_z_q  <= '0;
      stride_q <= plint_pkg::STRIDE_RESET;
      len_q    <= plint_pkg::LENGTH_RESET;
      auto_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        plint_pkg::CFG_OFFSET_X:     off_x_q  <= cfg_data_i;
        plint_pkg::CFG_OFFSET_Y:     off_y_q  <= cfg_data_i;
        plint_pkg::CFG_OFFSET_Z:     off_z_q  <= cfg_data_i;
        plint_pkg::CFG_STRIDE:       stride_q <= cfg_data_i;
        plint_pkg::CFG_SEG_LENGTH:   len_q    <= cfg_data_i[plint_pkg::LenW-1:0];
        plint_pkg::CFG_AUTO_ADVANCE: auto_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- accept
  logic in_ready, in_fire;
  logic [3:0] act;
  logic is_set_ab, is_adv, is_eval, table_mode, idx_ok, rd_en;
  logic [plint_pkg::IdxW-1:0] idx, seg_eff, seg_rd, seg_after;
  logic [plint_pkg::CountW-1:0] cnt_eff, seg_plus, seg_inc;
  logic path_wrap, wrapped, path_end_c;
  logic signed [34:0] ph, st, len_s, step1, look, fwd, bwd, next_ph;
  logic signed [31:0] phase_next;

  logic signed [31:0] phase_q, phase_d;
  logic [plint_pkg::IdxW-1:0] seg_q, seg_d;
  logic [plint_pkg::CountW-1:0] count_q, count_d;

  assign in_fire = in_i.valid && in_ready;
  assign act     = in_i.data.action;
  assign idx     = in_i.data.point_index;
  assign idx_ok  = int'(idx) < MAX_POINTS;

  assign is_set_ab = (act == plint_pkg::ACT_SET_A) || (act == plint_pkg::ACT_SET_B);
  assign is_adv    = (act == plint_pkg::ACT_ADVANCE) ||
                     (auto_q && (is_set_ab || (act == plint_pkg::ACT_SET_SEGMENT)));
  assign is_eval   = act == plint_pkg::ACT_EVALUATE;

  // set_a/set_b drop to two points and set_segment loads the index before the advance
  assign cnt_eff    = is_set_ab ? plint_pkg::COUNT_TWO : count_q;
  assign seg_eff    = (act == plint_pkg::ACT_SET_SEGMENT) ? idx : seg_q;
  assign table_mode = cnt_eff > plint_pkg::COUNT_TWO;

  // a segment past the last one reads as segment zero
  assign seg_plus = {1'b0, seg_eff} + 7'd1;
  assign seg_rd   = (seg_plus >= cnt_eff) ? '0 : seg_eff;
  assign seg_inc  = {1'b0, seg_rd} + 7'd1;

  assign ph    = 35'(phase_q);
  assign st    = 35'(stride_q);
  assign len_s = signed'({4'b0000, len_q});
  assign step1 = ph + st;
  assign look  = ph + st + st;
  assign fwd   = look - len_s;
  assign bwd   = look + len_s;

  always_comb begin
    wrapped = 1'b1;
    if (look > len_s) begin
      next_ph = fwd;
    end else if (look < 35'sd0) begin
      next_ph = bwd;
    end else begin
      next_ph = step1;
      wrapped = 1'b0;
    end
  end

  assign phase_next = sat32(51'(next_ph));
  assign path_wrap  = seg_inc > (cnt_eff - plint_pkg::COUNT_TWO);
  assign seg_after  = wrapped ? (path_wrap ? '0 : seg_inc[plint_pkg::IdxW-1:0]) : seg_rd;
  assign path_end_c = table_mode && wrapped && path_wrap;
  assign rd_en      = in_fire && is_adv && table_mode;

  always_comb begin
    phase_d = phase_q;
    seg_d   = seg_q;
    count_d = count_q;
    case (act)
      plint_pkg::ACT_SET_A, plint_pkg::ACT_SET_B: begin
        count_d = plint_pkg::COUNT_TWO;
      end
      plint_pkg::ACT_STACK, plint_pkg::ACT_MOVETO: begin
        count_d = plint_pkg::COUNT_ONE;
      end
      plint_pkg::ACT_LOAD_POINT: begin
        if (idx_ok && in_i.data.last_point) begin
          count_d = {1'b0, idx} + 7'd1;
        end
      end
      plint_pkg::ACT_SET_SEGMENT: begin
        seg_d = idx;
      end
      plint_pkg::ACT_SET_PHASE: begin
        phase_d = in_i.data.position;
      end
      default: ;
    endcase
    if (is_adv) begin
      phase_d = phase_next;
      if (table_mode) begin
        seg_d = seg_after;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      seg_q   <= '0;
      count_q <= plint_pkg::COUNT_TWO;
    end else if (in_fire) begin
      phase_q <= phase_d;
      seg_q   <= seg_d;
      count_q <= count_d;
    end
  end

  // ---------------------------------------------------------------- store
  plint_pkg::point_t wr_pt, rd0, rd1;

  assign wr_pt = '{x: in_i.data.coord_x, y: in_i.data.coord_y, z: in_i.data.coord_z};

  plint_store #(
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (in_fire && (act == plint_pkg::ACT_LOAD_POINT) && idx_ok),
    .waddr_i  (AW'(idx)),
    .wdata_i  (wr_pt),
    .re_i     (rd_en),
    .raddr0_i (AW'(seg_rd)),
    .raddr1_i (AW'(seg_inc)),
    .rdata0_o (rd0),
    .rdata1_o (rd1)
  );

  // ---------------------------------------------------------------- stage 1
  logic   s1_v_q, s1_leave, s1_rdy;
  s1_op_t s1_q;
  logic   s2_v_q, s2_rdy, s3_v_q, s3_rdy, out_v_q, out_rdy;
  plint_pkg::point_t a_q, b_q, a_new, b_new;

  assign s1_leave = s1_v_q && (!s1_q.emit || s2_rdy);
  assign s1_rdy   = !s1_v_q || s1_leave;
  assign in_ready = s1_rdy;
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.emit     <= is_adv || is_eval;
      s1_q.use_mem  <= is_adv && table_mode;
      s1_q.set_a    <= act == plint_pkg::ACT_SET_A;
      s1_q.set_b    <= act == plint_pkg::ACT_SET_B;
      s1_q.stack    <= act == plint_pkg::ACT_STACK;
      s1_q.moveto   <= act == plint_pkg::ACT_MOVETO;
      s1_q.coord    <= wr_pt;
      s1_q.pos      <= is_adv ? phase_q : in_i.data.position;
      s1_q.seg_end  <= is_adv && wrapped;
      s1_q.path_end <= is_adv && path_end_c;
    end
  end

  // endpoint edits apply in item order here, so the emit sees the updated pair
  always_comb begin
    a_new = a_q;
    b_new = b_q;
    if (s1_q.use_mem) begin
      a_new = rd0;
      b_new = rd1;
    end else if (s1_q.set_a) begin
      a_new = s1_q.coord;
    end else if (s1_q.set_b) begin
      b_new = s1_q.coord;
    end else if (s1_q.stack) begin
      a_new = b_q;
      b_new = s1_q.coord;
    end else if (s1_q.moveto) begin
      a_new = s1_q.coord;
      b_new = s1_q.coord;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '{x: 32'sd0, y: plint_pkg::ONE_Q16, z: plint_pkg::ONE_Q16};
    end else if (s1_leave) begin
      a_q <= a_new;
      b_q <= b_new;
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic signed [32:0] s2_dx_q, s2_dy_q, s2_dz_q;
  logic signed [31:0] s2_pos_q;
  plint_pkg::point_t  s2_a_q;
  logic               s2_seg_q, s2_path_q;

  assign s2_rdy = !s2_v_q || s3_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_q <= s1_v_q && s1_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_rdy && s1_v_q && s1_q.emit) begin
      s2_dx_q   <= 33'(b_new.x) - 33'(a_new.x);
      s2_dy_q   <= 33'(b_new.y) - 33'(a_new.y);
      s2_dz_q   <= 33'(b_new.z) - 33'(a_new.z);
      s2_pos_q  <= s1_q.pos;
      s2_a_q    <= a_new;
      s2_seg_q  <= s1_q.seg_end;
      s2_path_q <= s1_q.path_end;
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic signed [64:0] s3_px_q, s3_py_q, s3_pz_q;
  plint_pkg::point_t  s3_a_q;
  logic               s3_seg_q, s3_path_q;

  assign s3_rdy = !s3_v_q || out_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (s3_rdy) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_rdy && s2_v_q) begin
      s3_px_q   <= 65'(s2_pos_q) * 65'(s2_dx_q);
      s3_py_q   <= 65'(s2_pos_q) * 65'(s2_dy_q);
      s3_pz_q   <= 65'(s2_pos_q) * 65'(s2_dz_q);
      s3_a_q    <= s2_a_q;
      s3_seg_q  <= s2_seg_q;
      s3_path_q <= s2_path_q;
    end
  end

  // ---------------------------------------------------------------- output
  logic signed [50:0] sum_x, sum_y, sum_z;
  plint_pkg::out_item_t out_q;

  // arithmetic shift floors, matching round toward minus infinity
  assign sum_x = 51'(s3_a_q.x) + 51'(s3_px_q >>> 16) + 51'(off_x_q);
  assign sum_y = 51'(s3_a_q.y) + 51'(s3_py_q >>> 16) + 51'(off_y_q);
  assign sum_z = 51'(s3_a_q.z) + 51'(s3_pz_q >>> 16) + 51'(off_z_q);

  assign out_rdy = !out_v_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_rdy) begin
      out_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && s3_v_q) begin
      out_q.out_x       <= sat32(sum_x);
      out_q.out_y       <= sat32(sum_y);
      out_q.out_z       <= sat32(sum_z);
      out_q.segment_end <= s3_seg_q;
      out_q.path_end    <= s3_path_q;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  // ---------------------------------------------------------------- checks
  `PLINT_ASSERT(a_set_phase, in_fire && (act == plint_pkg::ACT_SET_PHASE) |=> phase_q == $past(in_i.data.position), "set_phase beat did not load the phase")
  `PLINT_ASSERT(a_rd_bound, rd_en |-> seg_inc < cnt_eff, "segment read passes the last point")
  `PLINT_ASSERT(a_out_src, $rose(out_v_q) |-> $past(s3_v_q), "result appeared without a product stage beat")
  `PLINT_ASSERT(a_stall_chain, !in_ready |-> s1_v_q && s1_q.emit && s2_v_q, "input stalled with room in the pipeline")
  `PLINT_ASSERT(a_count_max, int'(count_q) <= MAX_POINTS, "point count beyond store depth")

endmodule

`default_nettype wire

// ----- sv/plint_store.sv -----
// Point store: one write port, two registered read ports.
`default_nettype none

module plint_store #(
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire plint_pkg::point_t        wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1_i,
  output plint_pkg::point_t             rdata0_o,
  output plint_pkg::point_t             rdata1_o
);

  plint_pkg::point_t mem_q [DEPTH];
  plint_pkg::point_t rdata0_q;
  plint_pkg::point_t rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while the pipeline stalls
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata0_q <= mem_q[raddr0_i];
      rdata1_q <= mem_q[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

`default_nettype wire
